### design/amcdf_pkg.sv
package amcdf_pkg;

  localparam int unsigned MaxRowsDef  = 64;
  localparam int unsigned MaxColsDef  = 64;
  localparam int unsigned FracBitsDef = 24;

  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned CdfW    = 25;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OpW     = 2;

  // Divider operand width: numerators and denominators stay below 2^47.
  localparam int unsigned DivW = 48;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FETCH = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_OK     = 2'd1,
    ST_ZERO   = 2'd2,
    ST_UNLOAD = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_ROWS = 1'd0,
    CFG_COLS = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_READ,
    FS_DIV_ROW,
    FS_DIV_CELL,
    FS_OUT
  } fsm_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

endpackage

### design/amcdf_div.sv
module amcdf_div import amcdf_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_req_t            req_i,
  output logic                done_o,
  output logic [CdfW-1:0]     quot_o
);

  // Restoring fractional divider: floor(num * 2^FRAC / den), one bit per cycle.
  localparam int unsigned CntW = $clog2(FracBits + 2);

  logic [DivW:0]    rem_q, rem_d;
  logic [DivW-1:0]  den_q;
  logic [CdfW-1:0]  quot_q, quot_d;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic [DivW:0]    shifted;
  logic             ge;

  always_comb begin
    shifted = {rem_q[DivW-1:0], 1'b0};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? shifted - {1'b0, den_q} : shifted;
    quot_d  = {quot_q[CdfW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(FracBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      // num <= den: integer quotient is 1 only when equal
      if (req_i.num >= req_i.den) begin
        rem_q  <= {1'b0, req_i.num - req_i.den};
        quot_q <= CdfW'(1);
      end else begin
        rem_q  <= {1'b0, req_i.num};
        quot_q <= '0;
      end
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

### design/amcdf_store.sv
module amcdf_store import amcdf_pkg::*; #(
  parameter int unsigned MaxRows = MaxRowsDef,
  parameter int unsigned MaxCols = MaxColsDef,
  localparam int unsigned RowAw = (MaxRows > 1) ? $clog2(MaxRows) : 1,
  localparam int unsigned ColAw = (MaxCols > 1) ? $clog2(MaxCols) : 1
) (
  input  logic                        clk_i,
  input  logic                        cell_we_i,
  input  logic [RowAw+ColAw-1:0]      cell_waddr_i,
  input  logic [39:0]                 cell_wdata_i,
  input  logic [RowAw+ColAw-1:0]      cell_raddr_i,
  output logic [39:0]                 cell_rdata_o,
  input  logic                        row_we_i,
  input  logic [RowAw-1:0]            row_waddr_i,
  input  logic [37:0]                 row_sum_wdata_i,
  input  logic [45:0]                 row_mid_wdata_i,
  input  logic [RowAw-1:0]            row_raddr_i,
  output logic [37:0]                 row_sum_rdata_o,
  output logic [45:0]                 row_mid_rdata_o
);

  // Cell and row memories; read data is registered.
  logic [39:0] cell_mem [2**(RowAw+ColAw)];
  logic [83:0] row_mem  [2**RowAw];

  always_ff @(posedge clk_i) begin
    if (cell_we_i) cell_mem[cell_waddr_i] <= cell_wdata_i;
    cell_rdata_o <= cell_mem[cell_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (row_we_i) row_mem[row_waddr_i] <= {row_sum_wdata_i, row_mid_wdata_i};
    {row_sum_rdata_o, row_mid_rdata_o} <= row_mem[row_raddr_i];
  end

endmodule

### design/angle_map_cdf_builder.sv
// Angle-map CDF builder. Load requests (operation 0) stream the hit counts in
// row-major order at one per cycle while in_stall_o is low; each load until
// the map is full writes the cell's midpoint running sum into the cell memory
// and, at the end of a row, the row sum and row midpoint sum into the row
// memory. Fetch requests (operation 1) read both memories (the read is issued
// at the accepting edge, data used in FS_READ), then run two restoring
// divisions, row then cell, on a shared one-bit-per-cycle divider; a served
// fetch passes through FS_READ, FS_DIV_ROW, FS_DIV_CELL and FS_OUT, and no
// request is taken until it has returned to FS_IDLE. A fetch that reports not
// loaded or an all-zero map, a clear and a load are answered without leaving
// FS_IDLE. Results carry FRACTION_BITS fraction bits (24 by default),
// truncated. A register write clears the map. Memories are not cleared: a
// fetch is served only after every cell in use has been loaded.
module angle_map_cdf_builder import amcdf_pkg::*; #(
  parameter int unsigned MAX_ROWS      = MaxRowsDef,
  parameter int unsigned MAX_COLS      = MaxColsDef,
  parameter int unsigned FRACTION_BITS = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OpW-1:0]      operation_i,
  input  logic [CountW-1:0]   cell_count_i,
  input  logic [IdxW-1:0]     fetch_row_i,
  input  logic [IdxW-1:0]     fetch_col_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CdfW-1:0]     row_cdf_o,
  output logic [CdfW-1:0]     cell_cdf_o,
  output logic [StatusW-1:0]  status_o
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned AW = RW + CW;

  // Configuration and map registers
  logic [CfgW-1:0] rows_cfg_q, cols_cfg_q;
  logic [8:0]      rows_used, cols_used;
  logic [RW-1:0]   ld_row_q;
  logic [CW-1:0]   ld_col_q;
  logic            full_q;
  logic [37:0]     run_sum_q;
  logic [43:0]     total_q;

  always_comb begin
    rows_used = (rows_cfg_q == '0) ? 9'd1 :
                ({2'b0, rows_cfg_q} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {2'b0, rows_cfg_q};
    cols_used = (cols_cfg_q == '0) ? 9'd1 :
                ({2'b0, cols_cfg_q} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {2'b0, cols_cfg_q};
  end

  // Controller
  fsm_e state_q, state_d;
  logic in_acc, out_acc, out_free;
  logic [RW-1:0] f_row_q;
  logic [CW-1:0] f_col_q;
  logic [8:0]    fr_sat, fc_sat;

  assign out_acc  = out_valid_o && !out_stall_i;
  assign out_free = !out_valid_o || !out_stall_i;
  assign in_stall_o = (state_q != FS_IDLE) || !out_free;
  assign in_acc   = in_valid_i && !in_stall_o;

  always_comb begin
    fr_sat = ({3'b0, fetch_row_i} >= rows_used) ? rows_used - 9'd1 : {3'b0, fetch_row_i};
    fc_sat = ({3'b0, fetch_col_i} >= cols_used) ? cols_used - 9'd1 : {3'b0, fetch_col_i};
  end

  logic is_load, is_fetch, is_clear, last_col, fetch_go;
  assign is_load  = in_acc && (op_e'(operation_i) == OP_LOAD);
  assign is_fetch = in_acc && (op_e'(operation_i) == OP_FETCH);
  assign is_clear = in_acc && (op_e'(operation_i) == OP_CLEAR);
  assign last_col = (9'(ld_col_q) == 9'(cols_used - 9'd1));
  assign fetch_go = is_fetch && full_q && (total_q != '0);

  // Read address: issue the read at the accepting edge so data is ready in FS_READ
  logic [RW-1:0] rd_row;
  logic [CW-1:0] rd_col;
  assign rd_row = fetch_go ? RW'(fr_sat) : f_row_q;
  assign rd_col = fetch_go ? CW'(fc_sat) : f_col_q;

  // Memories
  logic [39:0] cell_rd;
  logic [37:0] rsum_rd;
  logic [45:0] rmid_rd;
  logic [37:0] run_new;

  assign run_new = run_sum_q + 38'(cell_count_i);

  amcdf_store #(.MaxRows(MAX_ROWS), .MaxCols(MAX_COLS)) u_store (
    .clk_i,
    .cell_we_i       (is_load && !full_q),
    .cell_waddr_i    (AW'({ld_row_q, ld_col_q})),
    .cell_wdata_i    (40'({run_sum_q, 1'b0}) + 40'(cell_count_i)),
    .cell_raddr_i    (AW'({rd_row, rd_col})),
    .cell_rdata_o    (cell_rd),
    .row_we_i        (is_load && !full_q && last_col),
    .row_waddr_i     (ld_row_q),
    .row_sum_wdata_i (run_new),
    .row_mid_wdata_i (46'({total_q, 1'b0}) + 46'(run_new)),
    .row_raddr_i     (rd_row),
    .row_sum_rdata_o (rsum_rd),
    .row_mid_rdata_o (rmid_rd)
  );

  // Divider
  div_req_t div_req;
  logic div_done;
  logic [CdfW-1:0] div_q;
  logic [DivW-1:0] cell_num_q, cell_den_q;

  amcdf_div #(.FracBits(FRACTION_BITS)) u_div (
    .clk_i, .rst_ni,
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_q)
  );

  always_comb begin
    state_d = state_q;
    div_req = '0;
    unique case (state_q)
      FS_IDLE:  if (fetch_go) state_d = FS_READ;
      FS_READ:  begin
        // Start the row division with the just-read memory data
        div_req.start = 1'b1;
        div_req.num   = DivW'(rmid_rd);
        div_req.den   = DivW'({total_q, 1'b0});
        state_d       = FS_DIV_ROW;
      end
      FS_DIV_ROW: if (div_done) begin
        div_req.start = 1'b1;
        div_req.num   = cell_num_q;
        div_req.den   = cell_den_q;
        state_d       = FS_DIV_CELL;
      end
      FS_DIV_CELL: if (div_done) state_d = FS_OUT;
      FS_OUT:   if (out_free) state_d = FS_IDLE;
      default:  state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FS_IDLE;
      rows_cfg_q <= CfgW'(64);
      cols_cfg_q <= CfgW'(64);
      ld_row_q   <= '0;
      ld_col_q   <= '0;
      full_q     <= 1'b0;
      run_sum_q  <= '0;
      total_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i || is_clear) begin
        ld_row_q <= '0; ld_col_q <= '0; full_q <= 1'b0;
        run_sum_q <= '0; total_q <= '0;
      end else if (is_load && !full_q) begin
        if (last_col) begin
          run_sum_q <= '0;
          total_q   <= total_q + 44'(run_new);
          ld_col_q  <= '0;
          if (9'(ld_row_q) == 9'(rows_used - 9'd1)) full_q <= 1'b1;
          else ld_row_q <= ld_row_q + RW'(1);
        end else begin
          run_sum_q <= run_new;
          ld_col_q  <= ld_col_q + CW'(1);
        end
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_ROWS: rows_cfg_q <= cfg_data_i;
          CFG_COLS: cols_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if ((in_acc && !fetch_go) || (state_q == FS_OUT && out_free)) out_valid_o <= 1'b1;
      else if (out_acc) out_valid_o <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (fetch_go) begin
      f_row_q <= RW'(fr_sat);
      f_col_q <= CW'(fc_sat);
    end
    if (state_q == FS_READ) begin
      if (rsum_rd == '0) begin
        cell_num_q <= DivW'({f_col_q, 1'b1});
        cell_den_q <= DivW'({cols_used, 1'b0});
      end else begin
        cell_num_q <= DivW'(cell_rd);
        cell_den_q <= DivW'({rsum_rd, 1'b0});
      end
    end
    if (state_q == FS_DIV_ROW && div_done) row_cdf_o <= div_q;
    if (state_q == FS_DIV_CELL && div_done) cell_cdf_o <= div_q;
    if (in_acc && !fetch_go) begin
      row_cdf_o  <= '0;
      cell_cdf_o <= '0;
      if (is_fetch) status_o <= full_q ? ST_ZERO : ST_UNLOAD;
      else          status_o <= ST_DONE;
    end
    if (state_q == FS_OUT && out_free) status_o <= ST_OK;
  end

  // Checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != FS_IDLE) |-> !in_acc) else $error("request taken during fetch");
  a_fetch_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_go |=> (state_q == FS_READ)) else $error("fetch did not start");
  a_full_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q && is_load) |=> ($stable(total_q))) else $error("load past full map");

endmodule
